// ===== design/lct_pkg.sv =====
package lct_pkg;

   // Request commands
   typedef enum logic [1:0] {
      CMD_READ       = 2'd0,
      CMD_WRITE      = 2'd1,
      CMD_CLAIM      = 2'd2,
      CMD_ADD_REGION = 2'd3
   } cmd_type;

   // Control register indexes
   localparam logic CSR_WARN_STALE    = 1'b0;
   localparam logic CSR_WARN_READONLY = 1'b1;

   localparam int ADDR_W    = 32;
   localparam int TILE_W    = 4;
   localparam int SHARERS_W = 16;

   // Request word held while its line bitmap is read
   typedef struct packed {
      cmd_type             command;
      logic [ADDR_W-1:0]   address;
      logic [TILE_W-1:0]   tile;
      logic [ADDR_W-1:0]   region_end;
      logic                out_of_range;
   } item_type;

endpackage

// ===== design/line_coherence_tracker.sv =====
// Tracks, per cache line, which tiles hold an up-to-date copy, and checks writes
// against a small table of read-only regions. Each request word returns one
// response word. After reset the block sweeps the bitmap memory to zero, one
// line per cycle; req_stall stays high during that sweep while control
// register writes are taken as usual. After that it accepts one word per cycle
// while the response side does not stall: the line bitmap is read from a
// synchronous memory in the accept cycle, and for in-range reads, writes and
// claims is modified and written back when stage one advances, when the response
// word is loaded into the output register. A back-to-back access to the same
// line is served from a forwarding register, so the memory read/modify/write
// loop does not limit the accept rate.
module line_coherence_tracker #(
   parameter int LINE_COUNT      = 32768,
   parameter int LINE_BYTES_LOG2 = 5,
   parameter int TILE_COUNT      = 16,
   parameter int REGION_COUNT    = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  lct_pkg::cmd_type                 req_command,
   input  logic [lct_pkg::ADDR_W-1:0]       req_address,
   input  logic [lct_pkg::TILE_W-1:0]       req_tile,
   input  logic [lct_pkg::ADDR_W-1:0]       req_region_end,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_stale_write,
   output logic                             rsp_readonly_write,
   output logic                             rsp_out_of_range,
   output logic                             rsp_region_full,
   output logic [lct_pkg::SHARERS_W-1:0]    rsp_sharers,
   // control register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic                             csr_index,
   input  logic                             csr_data
);
   import lct_pkg::*;

   localparam int LINE_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
   localparam int RIDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
   localparam int RCNT_W = $clog2(REGION_COUNT + 1);

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   logic warn_stale_ff, warn_stale_in;
   logic warn_ro_ff, warn_ro_in;

   assign csr_ready = 1'b1;

   always_comb begin
      warn_stale_in = warn_stale_ff;
      warn_ro_in    = warn_ro_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WARN_STALE:    warn_stale_in = csr_data;
            CSR_WARN_READONLY: warn_ro_in    = csr_data;
            default:           ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Handshake and pipeline control
   // ------------------------------------------------------------------
   logic             clearing_ff, clearing_in;
   logic [LINE_W-1:0] clear_idx_ff, clear_idx_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             s1_adv;
   logic             req_accept;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = clearing_ff || (s1_valid_ff && !s1_adv);
   assign req_accept = req_valid && !req_stall;

   // Sweep the bitmap memory after reset
   always_comb begin
      clearing_in  = clearing_ff;
      clear_idx_in = clear_idx_ff;
      if (clearing_ff) begin
         clear_idx_in = clear_idx_ff + LINE_W'(1);
         if (clear_idx_ff == LINE_W'(LINE_COUNT - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_comb begin
      priority if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      priority if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ------------------------------------------------------------------
   // Request decode and stage-one item register
   // ------------------------------------------------------------------
   logic [ADDR_W-1:0] req_line_full;
   logic [LINE_W-1:0] req_line;
   logic              req_oor;
   item_type          s1_item_ff, s1_item_in;
   logic [LINE_W-1:0] s1_line_ff, s1_line_in;

   assign req_line_full = req_address >> LINE_BYTES_LOG2;
   assign req_line      = req_line_full[LINE_W-1:0];
   assign req_oor       = (req_line_full >= ADDR_W'(LINE_COUNT));

   always_comb begin
      s1_item_in = s1_item_ff;
      s1_line_in = s1_line_ff;
      if (req_accept) begin
         s1_item_in.command      = req_command;
         s1_item_in.address      = req_address;
         s1_item_in.tile         = req_tile;
         s1_item_in.region_end   = req_region_end;
         s1_item_in.out_of_range = req_oor;
         s1_line_in              = req_line;
      end
   end

   // ------------------------------------------------------------------
   // Bitmap memory: read on accept, write back on advance
   // ------------------------------------------------------------------
   logic [TILE_COUNT-1:0] bitmap_mem [LINE_COUNT];
   logic [TILE_COUNT-1:0] mem_rdata_ff;
   logic                  mem_we;
   logic [LINE_W-1:0]     mem_waddr;
   logic [TILE_COUNT-1:0] mem_wdata;
   logic                  s1_wr;
   logic [TILE_COUNT-1:0] s1_new_bits;

   assign s1_wr = s1_adv && (s1_item_ff.command != CMD_ADD_REGION) &&
                  !s1_item_ff.out_of_range;

   always_comb begin
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clear_idx_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = s1_wr;
         mem_waddr = s1_line_ff;
         mem_wdata = s1_new_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      if (req_accept) begin
         mem_rdata_ff <= bitmap_mem[req_line];
      end
   end

   // Forward a write-back that lands on the line being read in the same cycle
   logic                  fwd_valid_ff, fwd_valid_in;
   logic [TILE_COUNT-1:0] fwd_bits_ff, fwd_bits_in;

   always_comb begin
      fwd_valid_in = fwd_valid_ff;
      fwd_bits_in  = fwd_bits_ff;
      if (req_accept) begin
         fwd_valid_in = s1_wr && (req_line == s1_line_ff);
         fwd_bits_in  = s1_new_bits;
      end
   end

   // ------------------------------------------------------------------
   // Read-only region table
   // ------------------------------------------------------------------
   logic [ADDR_W-1:0] region_base_ff  [REGION_COUNT];
   logic [ADDR_W-1:0] region_limit_ff [REGION_COUNT];
   logic [RCNT_W-1:0] region_count_ff, region_count_in;
   logic              region_add;
   logic              region_full;
   logic [REGION_COUNT-1:0] region_hit_vec;
   logic              region_hit;

   assign region_full = (region_count_ff >= RCNT_W'(REGION_COUNT));
   assign region_add  = s1_adv && (s1_item_ff.command == CMD_ADD_REGION) && !region_full;

   always_comb begin
      region_count_in = region_count_ff;
      if (region_add) begin
         region_count_in = region_count_ff + RCNT_W'(1);
      end
   end

   // Append an entry at the current fill count
   always_ff @(posedge clock) begin
      if (region_add) begin
         region_base_ff[region_count_ff[RIDX_W-1:0]]  <= s1_item_ff.address;
         region_limit_ff[region_count_ff[RIDX_W-1:0]] <= s1_item_ff.region_end;
      end
   end

   // Compare against every entry in use
   for (genvar r = 0; r < REGION_COUNT; r++) begin : g_region
      assign region_hit_vec[r] = (RCNT_W'(r) < region_count_ff) &&
                                 (s1_item_ff.address >= region_base_ff[r]) &&
                                 (s1_item_ff.address < region_limit_ff[r]);
   end
   assign region_hit = |region_hit_vec;

   // ------------------------------------------------------------------
   // Modify the line bitmap and form the response word
   // ------------------------------------------------------------------
   logic [TILE_COUNT-1:0] s1_cur_bits;
   logic [TILE_COUNT-1:0] s1_mask;
   logic                  s1_stale;
   logic                  s1_ro;
   logic [TILE_COUNT+SHARERS_W-1:0] s1_sharers_wide;

   for (genvar t = 0; t < TILE_COUNT; t++) begin : g_mask
      assign s1_mask[t] = (32'(s1_item_ff.tile) == t);
   end

   assign s1_cur_bits = fwd_valid_ff ? fwd_bits_ff : mem_rdata_ff;

   always_comb begin
      s1_new_bits = s1_mask;
      s1_stale    = 1'b0;
      s1_ro       = 1'b0;
      unique case (s1_item_ff.command)
         CMD_READ: begin
            s1_new_bits = s1_cur_bits | s1_mask;
         end
         CMD_WRITE: begin
            s1_stale = warn_stale_ff && ((s1_cur_bits & s1_mask) == '0);
            s1_ro    = warn_ro_ff && region_hit;
         end
         CMD_CLAIM: begin
            s1_new_bits = s1_mask;
         end
         CMD_ADD_REGION: begin
            s1_new_bits = s1_mask;
         end
         default: ;
      endcase
   end

   assign s1_sharers_wide = {{SHARERS_W{1'b0}}, s1_new_bits};

   logic                 rsp_stale_ff, rsp_stale_in;
   logic                 rsp_ro_ff, rsp_ro_in;
   logic                 rsp_oor_ff, rsp_oor_in;
   logic                 rsp_full_ff, rsp_full_in;
   logic [SHARERS_W-1:0] rsp_sharers_ff, rsp_sharers_in;

   // Load the output register when stage one advances
   always_comb begin
      rsp_stale_in   = rsp_stale_ff;
      rsp_ro_in      = rsp_ro_ff;
      rsp_oor_in     = rsp_oor_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_sharers_in = rsp_sharers_ff;
      if (s1_adv) begin
         rsp_stale_in   = 1'b0;
         rsp_ro_in      = 1'b0;
         rsp_oor_in     = 1'b0;
         rsp_full_in    = 1'b0;
         rsp_sharers_in = '0;
         priority if (s1_item_ff.command == CMD_ADD_REGION) begin
            rsp_full_in = region_full;
         end else if (s1_item_ff.out_of_range) begin
            rsp_oor_in = 1'b1;
         end else begin
            rsp_stale_in   = s1_stale;
            rsp_ro_in      = s1_ro;
            rsp_sharers_in = s1_sharers_wide[SHARERS_W-1:0];
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_stale_write    = rsp_stale_ff;
   assign rsp_readonly_write = rsp_ro_ff;
   assign rsp_out_of_range   = rsp_oor_ff;
   assign rsp_region_full    = rsp_full_ff;
   assign rsp_sharers        = rsp_sharers_ff;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         warn_stale_ff   <= 1'b1;
         warn_ro_ff      <= 1'b1;
         clearing_ff     <= 1'b1;
         clear_idx_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         fwd_valid_ff    <= 1'b0;
         region_count_ff <= '0;
      end else begin
         warn_stale_ff   <= warn_stale_in;
         warn_ro_ff      <= warn_ro_in;
         clearing_ff     <= clearing_in;
         clear_idx_ff    <= clear_idx_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         fwd_valid_ff    <= fwd_valid_in;
         region_count_ff <= region_count_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff     <= s1_item_in;
      s1_line_ff     <= s1_line_in;
      fwd_bits_ff    <= fwd_bits_in;
      rsp_stale_ff   <= rsp_stale_in;
      rsp_ro_ff      <= rsp_ro_in;
      rsp_oor_ff     <= rsp_oor_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_sharers_ff <= rsp_sharers_in;
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_oor_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_oor_ff) |->
         (rsp_sharers_ff == '0 && !rsp_stale_ff && !rsp_ro_ff && !rsp_full_ff))
      else $error("out-of-range response carries other flags");

   a_region_bound: assert property (@(posedge clock) disable iff (reset)
      region_count_ff <= RCNT_W'(REGION_COUNT))
      else $error("region table fill count overflow");

   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      $rose(fwd_valid_ff) |-> $past(s1_wr))
      else $error("forwarding set without a write-back");

   a_no_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> (!s1_valid_ff && !rsp_valid_ff))
      else $error("request in flight during memory sweep");

endmodule

// ===== test/line_coherence_tracker_test.sv =====
`timescale 1ns / 100ps

module line_coherence_tracker_test;
   import lct_pkg::*;

   localparam int LINES       = 32768;
   localparam int LINE_LOG2   = 5;
   localparam int TILES       = 16;
   localparam int REGIONS     = 8;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN       = 8;

   // Pool of neighboring lines that the traffic keeps returning to
   localparam logic [ADDR_W-1:0] HOT_BASE = 32'h0004_0000;

   typedef struct packed {
      logic                 stale_write;
      logic                 readonly_write;
      logic                 out_of_range;
      logic                 region_full;
      logic [SHARERS_W-1:0] sharers;
   } outcome_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   cmd_type              req_command = CMD_READ;
   logic [ADDR_W-1:0]    req_address = '0;
   logic [TILE_W-1:0]    req_tile = '0;
   logic [ADDR_W-1:0]    req_region_end = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_stale_write;
   logic                 rsp_readonly_write;
   logic                 rsp_out_of_range;
   logic                 rsp_region_full;
   logic [SHARERS_W-1:0] rsp_sharers;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic                 csr_index = CSR_WARN_STALE;
   logic                 csr_data = 1'b0;

   // Predicted tracker state
   bit [SHARERS_W-1:0] sharer_map [LINES];
   logic [ADDR_W-1:0]  ro_base [REGIONS];
   logic [ADDR_W-1:0]  ro_limit [REGIONS];
   int                 ro_count = 0;
   bit                 stale_warn_on = 1'b1;
   bit                 readonly_warn_on = 1'b1;

   outcome_type pending_outcomes [$];
   int          fail_count = 0;
   int          cycle_count = 0;
   bit          quiet = 1'b0;

   line_coherence_tracker #(
      .LINE_COUNT(LINES),
      .LINE_BYTES_LOG2(LINE_LOG2),
      .TILE_COUNT(TILES),
      .REGION_COUNT(REGIONS)
   ) DUT (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Gap length: mostly none, some short, a few long
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // Apply one request word to the predicted state and return its response
   function automatic outcome_type track_access(cmd_type cmd, logic [ADDR_W-1:0] addr,
                                                 logic [TILE_W-1:0] tile,
                                                 logic [ADDR_W-1:0] limit);
      outcome_type          o;
      logic [SHARERS_W-1:0] mask;
      logic [SHARERS_W-1:0] cur;
      logic [ADDR_W-1:0]    line;
      o = '0;
      mask = (tile < TILES) ? SHARERS_W'(1) << tile : '0;
      line = addr >> LINE_LOG2;
      if (cmd == CMD_ADD_REGION) begin
         if (ro_count >= REGIONS) begin
            o.region_full = 1'b1;
         end else begin
            ro_base[ro_count] = addr;
            ro_limit[ro_count] = limit;
            ro_count++;
         end
      end else if (line >= LINES) begin
         o.out_of_range = 1'b1;
      end else begin
         cur = sharer_map[line];
         case (cmd)
            CMD_READ: cur = cur | mask;
            CMD_WRITE: begin
               if (stale_warn_on && (cur & mask) == '0)
                  o.stale_write = 1'b1;
               // only live entries are compared; empty or inverted ones never match
               for (int i = 0; i < ro_count; i++) begin
                  if (readonly_warn_on && addr >= ro_base[i] && addr < ro_limit[i])
                     o.readonly_write = 1'b1;
               end
               cur = mask;
            end
            default: cur = mask;
         endcase
         sharer_map[line] = cur;
         o.sharers = cur;
      end
      return o;
   endfunction

   // Send one request word; valid stays high on return
   task automatic send_request(cmd_type cmd, logic [ADDR_W-1:0] addr,
                               logic [TILE_W-1:0] tile, logic [ADDR_W-1:0] limit);
      int          gap;
      outcome_type predicted;
      gap = idle_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_address <= addr;
      req_tile <= tile;
      req_region_end <= limit;
      do @(posedge clock); while (req_stall);
      predicted = track_access(cmd, addr, tile, limit);
      pending_outcomes.insert(pending_outcomes.size(), predicted);
   endtask

   // Drop valid and hold until every response is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Write both warning enables back to back
   task automatic set_warnings(bit stale_on, bit readonly_on);
      csr_valid <= 1'b1;
      csr_index <= CSR_WARN_STALE;
      csr_data <= stale_on;
      do @(posedge clock); while (!csr_ready);
      stale_warn_on = stale_on;
      csr_index <= CSR_WARN_READONLY;
      csr_data <= readonly_on;
      do @(posedge clock); while (!csr_ready);
      readonly_warn_on = readonly_on;
      csr_valid <= 1'b0;
   endtask

   // Random stall on the response side, and check each response word
   always @(posedge clock) begin : response_check
      int          stall_left;
      outcome_type want;
      outcome_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left--;
      end else if (quiet || $urandom_range(0, 1) == 0) begin
         rsp_stall <= 1'b0;
         stall_left = quiet ? 0 : $urandom_range(0, 20);
      end else begin
         rsp_stall <= 1'b1;
         stall_left = idle_length();
      end

      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         got = {rsp_stale_write, rsp_readonly_write, rsp_out_of_range,
                rsp_region_full, rsp_sharers};
         if (pending_outcomes.size() == 0) begin
            if (fail_count < 10)
               $display("%0t: unexpected word: stale=%b ro=%b oor=%b full=%b sharers=%h",
                        $realtime, got.stale_write, got.readonly_write,
                        got.out_of_range, got.region_full, got.sharers);
            fail_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (got.stale_write !== want.stale_write ||
                got.readonly_write !== want.readonly_write ||
                got.out_of_range !== want.out_of_range ||
                got.region_full !== want.region_full ||
                got.sharers !== want.sharers) begin
               if (fail_count < 10)
                  $display("%0t: want s=%b r=%b o=%b f=%b sh=%h got s=%b r=%b o=%b f=%b sh=%h",
                           $realtime, want.stale_write, want.readonly_write,
                           want.out_of_range, want.region_full, want.sharers,
                           got.stale_write, got.readonly_write, got.out_of_range,
                           got.region_full, got.sharers);
               fail_count++;
            end
         end
      end
   end

   // Reads add sharers, writes and claims leave one owner
   task automatic test_sharer_tracking();
      send_request(CMD_READ, HOT_BASE, 4'd0, 32'h0);
      send_request(CMD_READ, HOT_BASE + 32'd31, 4'd15, 32'hFFFF_FFFF);
      send_request(CMD_WRITE, HOT_BASE + 32'd4, 4'd15, 32'h0);
      send_request(CMD_WRITE, HOT_BASE, 4'd3, 32'h0);
      send_request(CMD_CLAIM, HOT_BASE + 32'd17, 4'd7, 32'h0);
      send_request(CMD_READ, HOT_BASE, 4'd7, 32'h0);
      send_request(CMD_READ, 32'h000F_FFFF, 4'd9, 32'h0);
      send_request(CMD_WRITE, 32'h0, 4'd0, 32'h0);
   endtask

   // Addresses past the last line flag and leave state alone
   task automatic test_out_of_range();
      send_request(CMD_READ, 32'h0010_0000, 4'd5, 32'h0);
      send_request(CMD_WRITE, 32'hFFFF_FFFF, 4'd15, 32'h0);
      send_request(CMD_CLAIM, 32'h8000_0000, 4'd0, 32'h0);
   endtask

   // Fill the region table, overflow it, and probe region edges
   task automatic test_readonly_regions();
      send_request(CMD_ADD_REGION, HOT_BASE, 4'd0, HOT_BASE + 32'd64);
      send_request(CMD_ADD_REGION, 32'h0000_2000, 4'd0, 32'h0000_1000);
      send_request(CMD_ADD_REGION, 32'h0000_3000, 4'd0, 32'h0000_3000);
      send_request(CMD_ADD_REGION, 32'hFFFF_FFFE, 4'd15, 32'hFFFF_FFFF);
      send_request(CMD_ADD_REGION, HOT_BASE + 32'd176, 4'd0, HOT_BASE + 32'd232);
      send_request(CMD_ADD_REGION, HOT_BASE + 32'd384, 4'd0, HOT_BASE + 32'd416);
      send_request(CMD_ADD_REGION, 32'h000F_FFF0, 4'd0, 32'h0010_0010);
      send_request(CMD_ADD_REGION, HOT_BASE + 32'd288, 4'd0, HOT_BASE + 32'd289);
      send_request(CMD_ADD_REGION, 32'h0000_0100, 4'd0, 32'h0000_0200);
      send_request(CMD_WRITE, HOT_BASE + 32'd40, 4'd2, 32'h0);
      send_request(CMD_WRITE, 32'h0000_2000, 4'd2, 32'h0);
      send_request(CMD_WRITE, 32'h0000_3000, 4'd2, 32'h0);
      send_request(CMD_WRITE, HOT_BASE + 32'd64, 4'd2, 32'h0);
   endtask

   // Random traffic over the hot lines, across warning settings
   task automatic test_random_traffic();
      bit                stale_plan [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      bit                ro_plan [5]    = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
      cmd_type           cmd;
      logic [ADDR_W-1:0] addr;
      int                r;
      for (int p = 0; p < 5; p++) begin
         wait_idle();
         set_warnings(stale_plan[p], ro_plan[p]);
         for (int n = 0; n < 140; n++) begin
            // open each setting with a burst of back-to-back words
            quiet = (n < 30);
            r = $urandom_range(0, 99);
            if (r < 40)
               cmd = CMD_READ;
            else if (r < 75)
               cmd = CMD_WRITE;
            else if (r < 93)
               cmd = CMD_CLAIM;
            else
               cmd = CMD_ADD_REGION;
            r = $urandom_range(0, 99);
            if (r < 75)
               addr = HOT_BASE + 32'($urandom_range(0, 15)) * 32 + $urandom_range(0, 31);
            else if (r < 90)
               addr = $urandom_range(0, 32'h000F_FFFF);
            else
               addr = $urandom;
            send_request(cmd, addr, 4'($urandom_range(0, 15)), $urandom);
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_sharer_tracking();
      test_out_of_range();
      test_readonly_regions();
      test_random_traffic();

      wait_idle();
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0 && pending_outcomes.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
